// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the DNS response parser.
// Depends on nothing; users supply clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/drp_pkg.sv =====
// Package for the DNS response parser: parse phases, field kinds, result types.
// No dependencies.
package drp_pkg;

  // Parse phase; fixed-width field phases share their code with the field kind
  typedef enum logic [3:0] {
    PH_ID      = 4'd0,
    PH_FLAGS   = 4'd1,
    PH_QDCOUNT = 4'd2,
    PH_ANCOUNT = 4'd3,
    PH_NSCOUNT = 4'd4,
    PH_ARCOUNT = 4'd5,
    PH_QNAME   = 4'd6,
    PH_QTYPE   = 4'd7,
    PH_QCLASS  = 4'd8,
    PH_ATYPE   = 4'd9,
    PH_ACLASS  = 4'd10,
    PH_TTL     = 4'd11,
    PH_RDLEN   = 4'd12,
    PH_RDATA   = 4'd13,
    PH_APTR    = 4'd14,
    PH_DONE    = 4'd15
  } phase_t;

  localparam logic [3:0] KIND_NAME_CHAR = 4'd6;
  localparam logic [3:0] KIND_RDATA     = 4'd13;
  localparam logic [7:0] LABEL_DOT      = 8'h2E;

  typedef struct packed {
    logic        have;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [15:0] index;
    logic        last;
  } drp_result_t;

  typedef struct packed {
    phase_t phase;
  } drp_status_t;

endpackage

// ===== rtl/drp_byte_if.sv =====
// Channel interfaces of the DNS response parser: message bytes in, fields out.
// No dependencies.
interface drp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface drp_field_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [31:0] field_value;
  logic [15:0] record_index;
  logic        last_of_message;

  modport source (output valid, field_kind, field_value, record_index, last_of_message,
                  input ready);
  modport sink   (input valid, field_kind, field_value, record_index, last_of_message,
                  output ready);
endinterface

// ===== rtl/dns_response_parser_core.sv =====
// DNS response parser: takes one message byte per transfer and emits each field
// on completion. One byte is accepted every cycle at full rate while the field side
// keeps up; a field's last byte goes into the input register, one decode step moves
// the field into the result register, and it is offered from there, where it waits
// while the field side stalls. Depends on drp_pkg, drp_byte_if/drp_field_if,
// drp_parse_fsm and assert_macros.svh.
`include "assert_macros.svh"

module dns_response_parser_core import drp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  drp_byte_if.sink    bytes,
  drp_field_if.source fields
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_eom;
  logic        out_valid;
  drp_result_t out_res;
  logic        advance;
  drp_result_t res;
  drp_status_t status;

  // Decode moves when the result register is free or being emptied
  assign advance     = in_valid && (!out_valid || fields.ready);
  assign bytes.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data_byte;
      in_eom  <= bytes.end_of_message;
    end
  end

  drp_parse_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .data_byte      (in_byte),
    .end_of_message (in_eom),
    .result         (res),
    .status         (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.have;
    end else if (fields.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.have) out_res <= res;
  end

  assign fields.valid           = out_valid;
  assign fields.field_kind      = out_res.kind;
  assign fields.field_value     = out_res.value;
  assign fields.record_index    = out_res.index;
  assign fields.last_of_message = out_res.last;

  // A byte waiting behind a stalled result stays in the input register
  `ASSERT_NEXT(a_in_hold, in_valid && out_valid && !fields.ready, in_valid, "input byte lost during stall")
  // A final field leaves the parser finished or back at the header
  `ASSERT_NEXT(a_last_ends, advance && res.have && res.last, (status.phase == PH_DONE) || (status.phase == PH_ID), "final field but parse continues")
  // Data bytes only come out of the data phase
  `ASSERT_IMPL(a_rdata_phase, advance && res.have && (res.kind == KIND_RDATA), status.phase == PH_RDATA, "data byte outside data phase")

endmodule

// ===== rtl/drp_parse_fsm.sv =====
// Parse state machine: holds the parse state and decodes one message byte.
// Depends on drp_pkg.
module drp_parse_fsm import drp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output drp_result_t result,
  output drp_status_t status
);

  phase_t      phase, phase_next, phase_adv;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] acc, acc_next, acc_new;
  logic [15:0] question_total, question_total_next;
  logic [15:0] answer_total, answer_total_next;
  logic [15:0] record_counter, record_counter_next, rc_inc;
  logic [7:0]  label_left, label_left_next;
  logic        name_started, name_started_next;
  logic [15:0] data_left, data_left_next, data_dec;
  logic        field_end;

  // Shared datapath terms
  always_comb begin
    acc_new   = (byte_in_field == 2'd0) ? {24'd0, data_byte} : {acc[23:0], data_byte};
    field_end = (phase == PH_TTL) ? (byte_in_field == 2'd3) : (byte_in_field == 2'd1);
    rc_inc    = record_counter + 16'd1;
    data_dec  = data_left - 16'd1;
  end

  // Next state
  always_comb begin
    phase_adv           = phase;
    byte_in_field_next  = byte_in_field;
    acc_next            = acc;
    question_total_next = question_total;
    answer_total_next   = answer_total;
    record_counter_next = record_counter;
    label_left_next     = label_left;
    name_started_next   = name_started;
    data_left_next      = data_left;
    case (phase)
      PH_DONE: begin
      end
      PH_QNAME: begin
        if (label_left == 8'd0) begin
          if (data_byte == 8'd0) begin
            phase_adv          = PH_QTYPE;
            byte_in_field_next = 2'd0;
          end else begin
            name_started_next = 1'b1;
            label_left_next   = data_byte;
          end
        end else begin
          label_left_next = label_left - 8'd1;
        end
      end
      PH_RDATA: begin
        data_left_next = data_dec;
        if (data_dec == 16'd0) begin
          record_counter_next = rc_inc;
          phase_adv = (rc_inc < answer_total) ? PH_APTR : PH_DONE;
        end
      end
      default: begin
        acc_next = acc_new;
        if (!field_end) begin
          byte_in_field_next = byte_in_field + 2'd1;
        end else begin
          byte_in_field_next = 2'd0;
          case (phase)
            PH_QDCOUNT: begin
              question_total_next = acc_new[15:0];
              phase_adv = PH_ANCOUNT;
            end
            PH_ANCOUNT: begin
              answer_total_next = acc_new[15:0];
              phase_adv = PH_NSCOUNT;
            end
            PH_ARCOUNT: begin
              record_counter_next = 16'd0;
              if (question_total != 16'd0) begin
                label_left_next   = 8'd0;
                name_started_next = 1'b0;
                phase_adv         = PH_QNAME;
              end else begin
                phase_adv = (answer_total != 16'd0) ? PH_APTR : PH_DONE;
              end
            end
            PH_QCLASS: begin
              if (rc_inc < question_total) begin
                record_counter_next = rc_inc;
                label_left_next     = 8'd0;
                name_started_next   = 1'b0;
                phase_adv           = PH_QNAME;
              end else begin
                record_counter_next = 16'd0;
                phase_adv = (answer_total != 16'd0) ? PH_APTR : PH_DONE;
              end
            end
            PH_RDLEN: begin
              data_left_next = acc_new[15:0];
              if (acc_new[15:0] == 16'd0) begin
                record_counter_next = rc_inc;
                phase_adv = (rc_inc < answer_total) ? PH_APTR : PH_DONE;
              end else begin
                phase_adv = PH_RDATA;
              end
            end
            PH_APTR: phase_adv = PH_ATYPE;
            default: phase_adv = phase_t'(phase + 4'd1);
          endcase
        end
      end
    endcase

    // End of message returns everything to the reset state
    phase_next = phase_adv;
    if (end_of_message) begin
      phase_next          = PH_ID;
      byte_in_field_next  = 2'd0;
      acc_next            = 32'd0;
      question_total_next = 16'd0;
      answer_total_next   = 16'd0;
      record_counter_next = 16'd0;
      label_left_next     = 8'd0;
      name_started_next   = 1'b0;
      data_left_next      = 16'd0;
    end
  end

  // Result of the current byte
  always_comb begin
    result.have  = 1'b0;
    result.kind  = phase;
    result.value = acc_new;
    result.index = record_counter;
    case (phase)
      PH_DONE: begin
      end
      PH_QNAME: begin
        result.kind = KIND_NAME_CHAR;
        if (label_left == 8'd0) begin
          result.have  = (data_byte != 8'd0) && name_started;
          result.value = {24'd0, LABEL_DOT};
        end else begin
          result.have  = 1'b1;
          result.value = {24'd0, data_byte};
        end
      end
      PH_RDATA: begin
        result.have  = 1'b1;
        result.kind  = KIND_RDATA;
        result.value = {24'd0, data_byte};
      end
      default: begin
        result.have = field_end && (phase != PH_APTR);
        if (phase <= PH_ARCOUNT) result.index = 16'd0;
      end
    endcase
    result.last = result.have && (end_of_message || (phase_adv == PH_DONE));
  end

  assign status.phase = phase;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID;
      byte_in_field  <= 2'd0;
      acc            <= 32'd0;
      question_total <= 16'd0;
      answer_total   <= 16'd0;
      record_counter <= 16'd0;
      label_left     <= 8'd0;
      name_started   <= 1'b0;
      data_left      <= 16'd0;
    end else if (en) begin
      phase          <= phase_next;
      byte_in_field  <= byte_in_field_next;
      acc            <= acc_next;
      question_total <= question_total_next;
      answer_total   <= answer_total_next;
      record_counter <= record_counter_next;
      label_left     <= label_left_next;
      name_started   <= name_started_next;
      data_left      <= data_left_next;
    end
  end

endmodule

// ===== tb/sv/drp_field_checker.sv =====
// Field checker for the DNS response parser: watches the byte and field channels,
// predicts every field from the accepted bytes and compares in order.
// Depends on drp_pkg and the drp_byte_if / drp_field_if interfaces.
module drp_field_checker import drp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  drp_byte_if   bytes,
  drp_field_if  fields,
  output int    errors,
  output int    outstanding
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [15:0] index;
    logic        last;
  } field_rec_t;

  field_rec_t expected_fields[$];

  // Parser state as the predictor sees it
  phase_t      phase;
  logic [1:0]  byte_cnt;
  logic [31:0] acc;
  logic [15:0] qd_total;
  logic [15:0] an_total;
  logic [15:0] rec_num;
  logic [7:0]  label_left;
  logic        in_name;
  logic [15:0] data_left;

  function void clear_parse();
    phase      = PH_ID;
    byte_cnt   = 2'd0;
    acc        = 32'd0;
    qd_total   = 16'd0;
    an_total   = 16'd0;
    rec_num    = 16'd0;
    label_left = 8'd0;
    in_name    = 1'b0;
    data_left  = 16'd0;
  endfunction

  function void start_question();
    label_left = 8'd0;
    in_name    = 1'b0;
    phase      = PH_QNAME;
  endfunction

  function void start_answers();
    rec_num = 16'd0;
    phase   = (an_total != 16'd0) ? PH_APTR : PH_DONE;
  endfunction

  function void finish_answer();
    rec_num = rec_num + 16'd1;
    phase   = (rec_num < an_total) ? PH_APTR : PH_DONE;
  endfunction

  // Advance the parse by one message byte; queue the field it completes, if any
  function void parse_byte(input logic [7:0] data, input logic eom);
    field_rec_t f;
    logic       have;
    phase_t     ph;
    int         width;
    have = 1'b0;
    f    = '0;
    ph   = phase;
    if (ph == PH_DONE) begin
      // trailing bytes are dropped
    end else if (ph == PH_QNAME) begin
      f.index = rec_num;
      if (label_left == 8'd0) begin
        if (data == 8'd0) begin
          phase    = PH_QTYPE;
          byte_cnt = 2'd0;
        end else begin
          // dot between labels; pointer-style lengths count as plain lengths
          if (in_name) begin
            have    = 1'b1;
            f.kind  = KIND_NAME_CHAR;
            f.value = {24'd0, LABEL_DOT};
          end
          in_name    = 1'b1;
          label_left = data;
        end
      end else begin
        have       = 1'b1;
        f.kind     = KIND_NAME_CHAR;
        f.value    = {24'd0, data};
        label_left = label_left - 8'd1;
      end
    end else if (ph == PH_RDATA) begin
      f.index   = rec_num;
      have      = 1'b1;
      f.kind    = KIND_RDATA;
      f.value   = {24'd0, data};
      data_left = data_left - 16'd1;
      if (data_left == 16'd0) finish_answer();
    end else begin
      // fixed-width big-endian fields
      width = (ph == PH_TTL) ? 4 : 2;
      acc   = (byte_cnt == 2'd0) ? {24'd0, data} : {acc[23:0], data};
      if (int'(byte_cnt) + 1 < width) begin
        byte_cnt = byte_cnt + 2'd1;
      end else begin
        byte_cnt = 2'd0;
        f.index  = (ph <= PH_ARCOUNT) ? 16'd0 : rec_num;
        if (ph != PH_APTR) begin
          have    = 1'b1;
          f.kind  = ph;
          f.value = acc;
        end
        case (ph)
          PH_QDCOUNT: begin
            qd_total = acc[15:0];
            phase    = PH_ANCOUNT;
          end
          PH_ANCOUNT: begin
            an_total = acc[15:0];
            phase    = PH_NSCOUNT;
          end
          PH_ARCOUNT: begin
            if (qd_total != 16'd0) begin
              rec_num = 16'd0;
              start_question();
            end else begin
              start_answers();
            end
          end
          PH_QCLASS: begin
            rec_num = rec_num + 16'd1;
            if (rec_num < qd_total) start_question();
            else start_answers();
          end
          PH_RDLEN: begin
            data_left = acc[15:0];
            if (data_left == 16'd0) finish_answer();
            else phase = PH_RDATA;
          end
          PH_APTR: phase = PH_ATYPE;
          default: phase = phase_t'(ph + 4'd1);
        endcase
      end
    end
    f.last = have && (eom || phase == PH_DONE);
    if (eom) clear_parse();
    if (have) expected_fields.insert(expected_fields.size(), f);
  endfunction

  // Compare one field transfer against the oldest prediction
  function void check_field();
    field_rec_t want;
    if (expected_fields.size() == 0) begin
      $error("unexpected field: kind %0d value %h index %0d", fields.field_kind,
             fields.field_value, fields.record_index);
      errors++;
      return;
    end
    want = expected_fields.pop_front();
    if (fields.field_kind !== want.kind) begin
      $error("field_kind: expected %0d, got %0d", want.kind, fields.field_kind);
      errors++;
    end
    if (fields.field_value !== want.value) begin
      $error("field_value: expected %h, got %h", want.value, fields.field_value);
      errors++;
    end
    if (fields.record_index !== want.index) begin
      $error("record_index: expected %0d, got %0d", want.index, fields.record_index);
      errors++;
    end
    if (fields.last_of_message !== want.last) begin
      $error("last_of_message: expected %0b, got %0b", want.last, fields.last_of_message);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_fields.delete();
    end else begin
      if (bytes.valid && bytes.ready) parse_byte(bytes.data_byte, bytes.end_of_message);
      if (fields.valid && fields.ready) check_field();
    end
    outstanding <= expected_fields.size();
  end

endmodule

// ===== tb/sv/dns_response_parser_core_test.sv =====
// Top of the DNS response parser testbench: clock, reset, byte stimulus, field
// back-pressure and verdict. Depends on the RTL, its interfaces and drp_field_checker.
module dns_response_parser_core_test;

  localparam int RANDOM_BYTES = 1050;
  localparam int CALM_START   = 500;
  localparam int CALM_SPAN    = 350;
  localparam int STALL_LIMIT  = 3000;

  typedef struct packed {
    logic       eom;
    logic [7:0] data;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   errors;
  int   outstanding;
  int   sent_bytes;
  int   calm_from;
  int   quiet_cycles;

  byte_item_t msg_q[$];

  drp_byte_if  bytes_ch();
  drp_field_if fields_ch();

  dns_response_parser_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .fields (fields_ch)
  );

  drp_field_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes_ch),
    .fields      (fields_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Field side back-pressure
  always @(posedge clk) begin
    fields_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (fields_ch.valid && fields_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Message building
  task automatic put_byte(input logic [7:0] data);
    byte_item_t item;
    item.eom  = 1'b0;
    item.data = data;
    msg_q.insert(msg_q.size(), item);
  endtask

  task automatic put_u16(input logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic put_u32(input logic [31:0] v);
    put_u16(v[31:16]);
    put_u16(v[15:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] qd, input logic [15:0] an,
                            input logic [15:0] ns, input logic [15:0] ar);
    put_u16(id);
    put_u16(flags);
    put_u16(qd);
    put_u16(an);
    put_u16(ns);
    put_u16(ar);
  endtask

  task automatic put_question(input int labels);
    int len;
    repeat (labels) begin
      len = $urandom_range(1, 6);
      put_byte(len[7:0]);
      repeat (len) put_byte(8'($urandom));
    end
    put_byte(8'd0);
    put_u16(16'($urandom));
    put_u16(16'($urandom));
  endtask

  task automatic put_answer(input logic [15:0] rdlen, input logic [31:0] ttl);
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    put_u32(ttl);
    put_u16(rdlen);
    repeat (rdlen) put_byte(8'($urandom));
  endtask

  task automatic close_message(input int trailing);
    repeat (trailing) put_byte(8'($urandom));
    msg_q[msg_q.size() - 1].eom = 1'b1;
  endtask

  // One byte transfer with random idle cycles before it
  task automatic send_byte(input byte_item_t item);
    calm <= (sent_bytes >= calm_from) && (sent_bytes < calm_from + CALM_SPAN);
    while (!calm && $urandom_range(0, 99) < 33) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid          <= 1'b1;
    bytes_ch.data_byte      <= item.data;
    bytes_ch.end_of_message <= item.eom;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_byte(msg_q[i]);
    msg_q.delete();
  endtask

  function automatic logic [15:0] random_rdlen();
    return 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6));
  endfunction

  // Mostly well-formed responses, some cut short, some pure noise
  task automatic make_random_message();
    int         pick;
    int         qd;
    int         an;
    int         cut;
    byte_item_t noise;
    pick = $urandom_range(0, 99);
    qd   = $urandom_range(0, 3);
    an   = $urandom_range(0, 3);
    if (pick < 88) begin
      put_header(16'($urandom), 16'($urandom), 16'(qd), 16'(an), 16'($urandom),
                 16'($urandom));
      repeat (qd) put_question($urandom_range(0, 3));
      repeat (an) put_answer(random_rdlen(), $urandom);
      if (pick < 72) begin
        close_message(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      end else begin
        cut = $urandom_range(1, msg_q.size());
        while (msg_q.size() > cut) void'(msg_q.pop_back());
        close_message(0);
      end
    end else if (pick < 94) begin
      // wide counts with a short random body, ended early
      put_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 30)) put_byte(8'($urandom));
      close_message(0);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        noise.eom  = ($urandom_range(0, 7) == 0);
        noise.data = 8'($urandom);
        msg_q.insert(msg_q.size(), noise);
      end
      close_message(0);
    end
  endtask

  initial begin
    rst                     = 1'b1;
    calm                    = 1'b0;
    sent_bytes              = 0;
    calm_from               = 32'h7FFF_FFFF;
    quiet_cycles            = 0;
    bytes_ch.valid          = 1'b0;
    bytes_ch.data_byte      = 8'd0;
    bytes_ch.end_of_message = 1'b0;
    fields_ch.ready         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Header only, no sections: arcount ends the parse; trailing byte ignored
    put_header(16'hFFFF, 16'h0000, 16'd0, 16'd0, 16'hFFFF, 16'h0000);
    close_message(1);
    send_message();

    // One question, two labels, no answers; end marker on qclass
    put_header(16'h0000, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    put_byte(8'd2);
    put_byte(8'h61);
    put_byte(8'h62);
    put_byte(8'd1);
    put_byte(8'h63);
    put_byte(8'd0);
    put_u16(16'h0001);
    put_u16(16'h0001);
    close_message(0);
    send_message();

    // No questions, zero-length data then three data bytes
    put_header(16'($urandom), 16'($urandom), 16'd0, 16'd2, 16'd0, 16'd0);
    put_answer(16'd0, 32'd0);
    put_answer(16'd3, $urandom);
    close_message(0);
    send_message();

    // Compression-pointer length taken as a plain length; all-ones TTL
    put_header(16'($urandom), 16'($urandom), 16'd1, 16'd1, 16'd0, 16'd0);
    put_byte(8'hC0);
    repeat (192) put_byte(8'($urandom));
    put_byte(8'd0);
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    put_answer(16'd1, 32'hFFFF_FFFF);
    close_message(2);
    send_message();

    // Largest counts, cut inside the first name
    put_header(16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    put_byte(8'd3);
    put_byte(8'h78);
    close_message(0);
    send_message();

    // Largest data length, cut in the data
    put_header(16'($urandom), 16'($urandom), 16'd0, 16'd1, 16'd0, 16'd0);
    put_u16(16'hC00C);
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    put_u32($urandom);
    put_u16(16'hFFFF);
    repeat (4) put_byte(8'($urandom));
    close_message(0);
    send_message();

    // Empty question name
    put_header(16'($urandom), 16'($urandom), 16'd1, 16'd0, 16'd0, 16'd0);
    put_question(0);
    close_message(0);
    send_message();

    // Lone end marker mid-header
    put_byte(8'h5A);
    close_message(0);
    send_message();

    // Random traffic
    calm_from = sent_bytes + CALM_START;
    begin
      int stop_at;
      stop_at = sent_bytes + RANDOM_BYTES;
      while (sent_bytes < stop_at) begin
        make_random_message();
        send_message();
      end
    end

    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outstanding != 0) $error("%0d expected fields never arrived", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/drp_pkg.sv
rtl/drp_byte_if.sv
rtl/drp_parse_fsm.sv
rtl/dns_response_parser_core.sv
tb/sv/drp_field_checker.sv
tb/sv/dns_response_parser_core_test.sv
